FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the shortest-path engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bfs check failed");
`define BFS_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bfs check failed");
`else
`define BFS_ASSERT(lbl, clk, rst_n, prop)
`define BFS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Types and codes shared by the shortest-path engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;
  localparam int unsigned NodeW = 6;

  typedef enum logic [1:0] {
    MODE_ADD_VERTEX = 2'd0,
    MODE_ADD_EDGE   = 2'd1,
    MODE_QUERY      = 2'd2,
    MODE_NONE       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_PATH    = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NOCONN  = 2'd2,
    STAT_ACK     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE_A, ST_EDGE_B, ST_EMIT, ST_Q_HEAD, ST_Q_CUR, ST_Q_ROW,
    ST_Q_SCAN, ST_Q_DONE, ST_P_PUSH, ST_P_PAR, ST_P_POP, ST_P_OUT
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic [NodeW-1:0] rd_addr;
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
  } adj_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/bfs_if.sv
// ----------------------------------------------------------------------------
// bfs_in_if / bfs_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface bfs_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [bfs_pkg::NodeW-1:0] node_a;
  logic [bfs_pkg::NodeW-1:0] node_b;
  modport source (output valid, mode, node_a, node_b, input ready);
  modport sink (input valid, mode, node_a, node_b, output ready);
endinterface

interface bfs_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [bfs_pkg::NodeW-1:0] vertex;
  logic                      last;
  modport source (output valid, status, vertex, last, input ready);
  modport sink (input valid, status, vertex, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bfs_adj_ram.sv
// ----------------------------------------------------------------------------
// bfs_adj_ram
// Adjacency row memory, one write and one registered read per cycle.
// Rows never written read as zero through per-row valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfs_adj_ram #(
  parameter int unsigned NODES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bfs_pkg::adj_cmd_t cmd_i,
  input  wire logic [NODES-1:0]  wr_data_i,
  output      logic [NODES-1:0]  rd_data_o
);
  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_vld_q;
  logic [NODES-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        row_vld_q[cmd_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= row_vld_q[cmd_i.rd_addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr[AW-1:0]] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;
endmodule
`default_nettype wire

FILE: rtl/core/bfs_shortest_path_engine_top.sv
// An edge update reads and rewrites both adjacency rows; a query visits vertices
// in breadth-first order, then walks parent links back to emit the path.
// One item is in work at a time; the adjacency memory read per dequeued
// vertex and the one-neighbor-per-cycle scan set the query time.
// Reset empties the graph at once through per-row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// bfs_shortest_path_engine_top
// Graph store and breadth-first shortest path search with path output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfs_shortest_path_engine_top #(
  parameter int unsigned NODES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfs_in_if.sink    in_i,
  bfs_out_if.source out_o
);
  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [bfs_pkg::NodeW:0] NodesW = (bfs_pkg::NodeW + 1)'(NODES);
  localparam logic [NODES-1:0] One = {{(NODES - 1){1'b0}}, 1'b1};

  bfs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [bfs_pkg::NodeW-1:0] out_vertex_q, out_vertex_d;
  logic             out_last_q, out_last_d;
  logic [NODES-1:0] present_q, present_d;
  logic [NODES-1:0] visited_q, visited_d;
  logic [AW:0]      head_q, head_d, tail_q, tail_d, len_q, len_d, pidx_q, pidx_d;
  logic [AW-1:0]    cur_q, cur_d, start_q, start_d, end_q, end_d, v_q, v_d;
  logic [AW-1:0]    a_q, a_d, b_q, b_d;
  logic [NODES-1:0] row_q, row_d;
  logic [1:0]       stat_q, stat_d;

  bfs_pkg::adj_cmd_t adj_cmd;
  logic [NODES-1:0]  adj_wdata, adj_rdata;

  logic          par_we, par_re, que_we, que_re, stk_we, stk_re;
  logic [AW-1:0] par_waddr, par_wdata, par_raddr, que_waddr, que_wdata, que_raddr;
  logic [AW-1:0] stk_waddr, stk_wdata, stk_raddr;
  logic [AW-1:0] par_mem [NODES];
  logic [AW-1:0] que_mem [NODES];
  logic [AW-1:0] stk_mem [NODES];
  logic [AW-1:0] par_rd_q, que_rd_q, stk_rd_q;

  logic [NODES-1:0] cand;
  logic [AW-1:0]    pick;
  logic             a_ok, b_ok, out_free;

  bfs_adj_ram #(.NODES(NODES)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (adj_cmd),
    .wr_data_i (adj_wdata),
    .rd_data_o (adj_rdata)
  );

  assign a_ok = ({1'b0, in_i.node_a} < NodesW) && present_q[in_i.node_a[AW-1:0]];
  assign b_ok = ({1'b0, in_i.node_b} < NodesW) && present_q[in_i.node_b[AW-1:0]];
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == bfs_pkg::ST_IDLE) && out_free;

  assign cand = row_q & ~visited_q;
  always_comb begin
    pick = '0;
    for (int k = NODES - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick = AW'(k);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_vertex_d = out_vertex_q;
    out_last_d = out_last_q;
    present_d = present_q;
    visited_d = visited_q;
    head_d = head_q;
    tail_d = tail_q;
    len_d = len_q;
    pidx_d = pidx_q;
    cur_d = cur_q;
    start_d = start_q;
    end_d = end_q;
    v_d = v_q;
    a_d = a_q;
    b_d = b_q;
    row_d = row_q;
    stat_d = stat_q;
    adj_cmd = '0;
    adj_wdata = '0;
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_re = 1'b0; par_raddr = v_q;
    que_we = 1'b0; que_waddr = '0; que_wdata = '0; que_re = 1'b0;
    que_raddr = head_q[AW-1:0];
    stk_we = 1'b0; stk_waddr = len_q[AW-1:0]; stk_wdata = v_q; stk_re = 1'b0;
    stk_raddr = pidx_q[AW-1:0];
    case (state_q)
      bfs_pkg::ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          a_d = in_i.node_a[AW-1:0];
          b_d = in_i.node_b[AW-1:0];
          start_d = in_i.node_a[AW-1:0];
          end_d = in_i.node_b[AW-1:0];
          out_vertex_d = '0;
          out_last_d = 1'b1;
          case (in_i.mode)
            bfs_pkg::MODE_ADD_VERTEX: begin
              out_valid_d = 1'b1;
              if ({1'b0, in_i.node_a} < NodesW) begin
                present_d[in_i.node_a[AW-1:0]] = 1'b1;
                out_status_d = bfs_pkg::STAT_ACK;
              end else begin
                out_status_d = bfs_pkg::STAT_INVALID;
              end
            end
            bfs_pkg::MODE_ADD_EDGE: begin
              if (!(a_ok && b_ok)) begin
                out_valid_d = 1'b1;
                out_status_d = bfs_pkg::STAT_INVALID;
              end else if (in_i.node_a == in_i.node_b) begin
                out_valid_d = 1'b1;
                out_status_d = bfs_pkg::STAT_ACK;
              end else begin
                adj_cmd.rd_en = 1'b1;
                adj_cmd.rd_addr = in_i.node_a;
                state_d = bfs_pkg::ST_EDGE_A;
              end
            end
            bfs_pkg::MODE_QUERY: begin
              if (!(a_ok && b_ok)) begin
                out_valid_d = 1'b1;
                out_status_d = bfs_pkg::STAT_INVALID;
              end else begin
                visited_d = One << in_i.node_a[AW-1:0];
                par_we = 1'b1;
                par_waddr = in_i.node_a[AW-1:0];
                par_wdata = in_i.node_a[AW-1:0];
                que_we = 1'b1;
                que_waddr = '0;
                que_wdata = in_i.node_a[AW-1:0];
                head_d = '0;
                tail_d = (AW + 1)'(1);
                state_d = bfs_pkg::ST_Q_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bfs_pkg::ST_EDGE_A: begin
        adj_cmd.wr_en = 1'b1;
        adj_cmd.wr_addr = bfs_pkg::NodeW'(a_q);
        adj_wdata = adj_rdata | (One << b_q);
        adj_cmd.rd_en = 1'b1;
        adj_cmd.rd_addr = bfs_pkg::NodeW'(b_q);
        state_d = bfs_pkg::ST_EDGE_B;
      end
      bfs_pkg::ST_EDGE_B: begin
        adj_cmd.wr_en = 1'b1;
        adj_cmd.wr_addr = bfs_pkg::NodeW'(b_q);
        adj_wdata = adj_rdata | (One << a_q);
        stat_d = bfs_pkg::STAT_ACK;
        state_d = bfs_pkg::ST_EMIT;
      end
      bfs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_status_d = stat_q;
          out_vertex_d = '0;
          out_last_d = 1'b1;
          state_d = bfs_pkg::ST_IDLE;
        end
      end
      bfs_pkg::ST_Q_HEAD: begin
        if (head_q < tail_q) begin
          que_re = 1'b1;
          state_d = bfs_pkg::ST_Q_CUR;
        end else begin
          state_d = bfs_pkg::ST_Q_DONE;
        end
      end
      bfs_pkg::ST_Q_CUR: begin
        cur_d = que_rd_q;
        head_d = head_q + 1'b1;
        if (que_rd_q == end_q) begin
          state_d = bfs_pkg::ST_Q_DONE;
        end else begin
          adj_cmd.rd_en = 1'b1;
          adj_cmd.rd_addr = bfs_pkg::NodeW'(que_rd_q);
          state_d = bfs_pkg::ST_Q_ROW;
        end
      end
      bfs_pkg::ST_Q_ROW: begin
        row_d = adj_rdata & present_q;
        state_d = bfs_pkg::ST_Q_SCAN;
      end
      bfs_pkg::ST_Q_SCAN: begin
        if (cand == '0) begin
          state_d = bfs_pkg::ST_Q_HEAD;
        end else begin
          visited_d[pick] = 1'b1;
          row_d[pick] = 1'b0;
          par_we = 1'b1;
          par_waddr = pick;
          par_wdata = cur_q;
          que_we = 1'b1;
          que_waddr = tail_q[AW-1:0];
          que_wdata = pick;
          tail_d = tail_q + 1'b1;
        end
      end
      bfs_pkg::ST_Q_DONE: begin
        if (!visited_q[end_q]) begin
          stat_d = bfs_pkg::STAT_NOCONN;
          state_d = bfs_pkg::ST_EMIT;
        end else begin
          v_d = end_q;
          len_d = '0;
          state_d = bfs_pkg::ST_P_PUSH;
        end
      end
      bfs_pkg::ST_P_PUSH: begin
        stk_we = 1'b1;
        len_d = len_q + 1'b1;
        if (v_q == start_q) begin
          pidx_d = len_q;
          state_d = bfs_pkg::ST_P_POP;
        end else begin
          par_re = 1'b1;
          state_d = bfs_pkg::ST_P_PAR;
        end
      end
      bfs_pkg::ST_P_PAR: begin
        v_d = par_rd_q;
        state_d = bfs_pkg::ST_P_PUSH;
      end
      bfs_pkg::ST_P_POP: begin
        stk_re = 1'b1;
        state_d = bfs_pkg::ST_P_OUT;
      end
      bfs_pkg::ST_P_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_status_d = bfs_pkg::STAT_PATH;
          out_vertex_d = bfs_pkg::NodeW'(stk_rd_q);
          out_last_d = (pidx_q == '0);
          if (pidx_q == '0) begin
            state_d = bfs_pkg::ST_IDLE;
          end else begin
            pidx_d = pidx_q - 1'b1;
            state_d = bfs_pkg::ST_P_POP;
          end
        end
      end
      default: begin
        state_d = bfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      present_q <= '0;
      visited_q <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      present_q <= present_d;
      visited_q <= visited_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_vertex_q <= out_vertex_d;
    out_last_q <= out_last_d;
    len_q <= len_d;
    pidx_q <= pidx_d;
    cur_q <= cur_d;
    start_q <= start_d;
    end_q <= end_d;
    v_q <= v_d;
    a_q <= a_d;
    b_q <= b_d;
    row_q <= row_d;
    stat_q <= stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (par_re) begin
      par_rd_q <= par_mem[par_raddr];
    end
    if (que_we) begin
      que_mem[que_waddr] <= que_wdata;
    end
    if (que_re) begin
      que_rd_q <= que_mem[que_raddr];
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.vertex = out_vertex_q;
  assign out_o.last = out_last_q;

  `BFS_ASSERT(a_head_le_tail, clk_i, rst_ni, head_q <= tail_q)
  `BFS_ASSERT(a_tail_bound, clk_i, rst_ni, tail_q <= (AW + 1)'(NODES))
  `BFS_ASSERT(a_start_visited, clk_i, rst_ni, state_q == bfs_pkg::ST_Q_SCAN |-> visited_q[start_q])
endmodule
`default_nettype wire
